FILE: hdl/lfcp_pkg.sv
package lfcp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFA;
  localparam int unsigned FRAME_LEN = 22;
  localparam int unsigned SUM_BYTES = 20;
  localparam int unsigned POS_W = 5;
  localparam int unsigned FOLD_SHIFT = 15;
  localparam logic [14:0] FOLD_MASK = 15'h7FFF;
  localparam int unsigned SPEED_FRAC_BITS = 6;

  localparam logic [POS_W-1:0] POS_SPEED_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CHECK_LO = POS_W'(SUM_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] speed_fixed;
    logic [31:0] valid_frames;
  } result_t;

endpackage

FILE: hdl/lfcp_ifs.sv
interface lfcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface lfcp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_fixed;
  logic [31:0] valid_frames;

  modport source(output valid, output speed_fixed, output valid_frames, input ready);
  modport sink(input valid, input speed_fixed, input valid_frames, output ready);
endinterface

FILE: hdl/lfcp_frame.sv
module lfcp_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output lfcp_pkg::result_t res
);

  lfcp_pkg::pos_t pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [7:0]  chk_lo_r, chk_lo_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic        hunting;
  logic [15:0] word;
  logic [31:0] acc_base;
  logic [17:0] fold_sum;
  logic [14:0] cs;
  logic        match;

  assign hunting  = (pos_r == '0) && (rx_byte != lfcp_pkg::SYNC_BYTE);
  assign word     = {rx_byte, low_r};
  assign acc_base = (pos_r == '0) ? 32'd0 : acc_r;
  assign fold_sum = {3'b000, acc_r[14:0]} + {1'b0, acc_r[31:lfcp_pkg::FOLD_SHIFT]};
  assign cs       = fold_sum[14:0] & lfcp_pkg::FOLD_MASK;
  assign match    = (cs[7:0] == chk_lo_r) && ({1'b0, cs[14:8]} == rx_byte);

  always_comb begin
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    low_nxt    = low_r;
    speed_nxt  = speed_r;
    chk_lo_nxt = chk_lo_r;
    cnt_nxt    = cnt_r;
    res.valid        = 1'b0;
    res.speed_fixed  = speed_r;
    res.valid_frames = cnt_r + 32'd1;
    if (step && !hunting) begin
      if (pos_r < lfcp_pkg::POS_CHECK_LO) begin
        if (!pos_r[0]) begin
          low_nxt = rx_byte;
          acc_nxt = acc_base;
        end else begin
          acc_nxt = {acc_base[30:0], 1'b0} + {16'd0, word};
          if (pos_r == lfcp_pkg::POS_SPEED_HI) begin
            speed_nxt = word;
          end
        end
        pos_nxt = pos_r + lfcp_pkg::POS_W'(1);
      end else if (pos_r == lfcp_pkg::POS_CHECK_LO) begin
        chk_lo_nxt = rx_byte;
        pos_nxt    = pos_r + lfcp_pkg::POS_W'(1);
      end else begin
        pos_nxt = '0;
        if (match) begin
          cnt_nxt   = cnt_r + 32'd1;
          res.valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      low_r    <= '0;
      speed_r  <= '0;
      chk_lo_r <= '0;
      cnt_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      low_r    <= low_nxt;
      speed_r  <= speed_nxt;
      chk_lo_r <= chk_lo_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/lfcp_out_stage.sv
module lfcp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lfcp_pkg::result_t res,
  output logic              free,
  lfcp_out_if.source        out_ch
);

  logic        valid_r, valid_nxt;
  logic [15:0] speed_r;
  logic [31:0] frames_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // load payload only with a new result
  always_ff @(posedge clk) begin
    if (free && step && res.valid) begin
      speed_r  <= res.speed_fixed;
      frames_r <= res.valid_frames;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.speed_fixed  = speed_r;
  assign out_ch.valid_frames = frames_r;

endmodule

FILE: hdl/lidar_frame_checksum_parser_core.sv
// A frame's result reaches out_ch via the input register, then the result register.
// Throughput: 1 byte per cycle while out_ch is not stalled; the input register and
// the result register overlap; the checksum does one shift and add per 16-bit word.
// A valid frame gives one result after its 22nd byte; invalid frames give none.
// Reset is synchronous, active low: parser hunts for sync, checksum and count clear.
module lidar_frame_checksum_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  lfcp_in_if.sink    in_ch,
  lfcp_out_if.source out_ch
);

  logic              in_v_r, in_v_nxt;
  logic [7:0]        in_byte_r;
  logic              out_free;
  logic              step;
  logic              in_fire;
  lfcp_pkg::result_t res;

  assign step        = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  lfcp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  lfcp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

FILE: hdl/lfcp_checker.sv
module lfcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_speed_fixed,
  input logic [31:0] out_valid_frames
);

  logic [31:0] last_frames_r;
  logic        out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frames_r <= '0;
    end else if (out_fire) begin
      last_frames_r <= out_valid_frames;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_fixed)
      && $stable(out_valid_frames))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_valid_frames == last_frames_r + 32'd1)
    else $error("valid frame count skipped or repeated");

endmodule

bind lidar_frame_checksum_parser_core lfcp_checker u_lfcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_speed_fixed  (out_ch.speed_fixed),
  .out_valid_frames (out_ch.valid_frames)
);
